// ----- src/quadratic_root_solver_macros.svh -----
// Assertion macros for the quadratic root solver.
// Needs no package; the caller passes clock, reset and expressions.
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// same-cycle implication, off during reset
`define QRS_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// implication after a fixed number of cycles
`define QRS_ASSERT_LAT(label, clk, rst, pre, lat, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> ##lat (post)) \
      else $error(msg);

`endif

// ----- src/qrs_pkg.sv -----
// Shared widths, kind codes and stage tag for the quadratic root solver.
// No dependencies.
`default_nettype none
package qrs_pkg;
   localparam int COEF_WIDTH = 16;
   localparam int FRAC_BITS  = 16;
   localparam int OUT_WIDTH  = 41;
   // discriminant magnitude: b*b + 4|a||c| stays below 2^(2W+1)
   localparam int MAG_W      = 2 * COEF_WIDTH + 1;
   localparam int SQRT_W     = (MAG_W + 1) / 2;
   localparam int RAD_W      = 2 * SQRT_W;
   localparam int REM_W      = SQRT_W + 2;
   localparam int NUM_MAG_W  = SQRT_W + 1;
   localparam int NUM_W      = NUM_MAG_W + 1;
   localparam int DEN_W      = COEF_WIDTH + 1;
   localparam int DVD_W      = NUM_MAG_W + FRAC_BITS;
   localparam int PIPE_LAT   = 2 + SQRT_W + 1 + DVD_W + 1;

   typedef enum logic [1:0] {
      KIND_TWO_REAL = 2'd0,
      KIND_DOUBLE   = 2'd1,
      KIND_COMPLEX  = 2'd2,
      KIND_NO_LEAD  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic signed [COEF_WIDTH:0] neg_b;
      logic [DEN_W-1:0]          den_mag;
      logic                      den_neg;
   } sq_tag_type;
endpackage
`default_nettype wire

// ----- src/qrs_front.sv -----
// Front end: coefficient magnitudes, products and discriminant classification.
// Two register stages. Uses qrs_pkg.
`default_nettype none
module qrs_front import qrs_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic signed [COEF_WIDTH-1:0] coef_a,
   input  wire logic signed [COEF_WIDTH-1:0] coef_b,
   input  wire logic signed [COEF_WIDTH-1:0] coef_c,
   output logic                              out_valid,
   output logic [MAG_W-1:0]                  out_mag,
   output sq_tag_type                        out_tag
);
   localparam int PW = 2 * COEF_WIDTH;

   logic [COEF_WIDTH-1:0] ma, mb, mc;
   logic v1_ff;
   logic [PW-1:0] bb_ff, ac_ff;
   logic [COEF_WIDTH-1:0] ma_ff;
   logic a_neg_ff, a_zero_ff, c_neg_ff, c_zero_ff;
   logic signed [COEF_WIDTH-1:0] b_ff;

   logic v2_ff;
   logic [MAG_W-1:0] mag_ff, mag_in;
   sq_tag_type tag_ff, tag_in;
   logic [PW+1:0] bb_x, ac4, sum;

   assign ma = coef_a[COEF_WIDTH-1] ? COEF_WIDTH'(-coef_a) : COEF_WIDTH'(coef_a);
   assign mb = coef_b[COEF_WIDTH-1] ? COEF_WIDTH'(-coef_b) : COEF_WIDTH'(coef_b);
   assign mc = coef_c[COEF_WIDTH-1] ? COEF_WIDTH'(-coef_c) : COEF_WIDTH'(coef_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      bb_ff     <= mb * mb;
      ac_ff     <= ma * mc;
      ma_ff     <= ma;
      a_neg_ff  <= coef_a[COEF_WIDTH-1];
      a_zero_ff <= (coef_a == '0);
      c_neg_ff  <= coef_c[COEF_WIDTH-1];
      c_zero_ff <= (coef_c == '0);
      b_ff      <= coef_b;
      mag_ff    <= mag_in;
      tag_ff    <= tag_in;
   end

   always_comb begin
      bb_x = {2'b00, bb_ff};
      ac4  = {ac_ff, 2'b00};
      sum  = bb_x + ac4;
      tag_in.neg_b   = -{b_ff[COEF_WIDTH-1], b_ff};
      tag_in.den_mag = {ma_ff, 1'b0};
      tag_in.den_neg = a_neg_ff;
      if (a_zero_ff) begin
         tag_in.kind = KIND_NO_LEAD;
         mag_in      = '0;
      end else if ((a_neg_ff != c_neg_ff) && !c_zero_ff) begin
         tag_in.kind = KIND_TWO_REAL;
         mag_in      = MAG_W'(sum);
      end else if (bb_x > ac4) begin
         tag_in.kind = KIND_TWO_REAL;
         mag_in      = MAG_W'(bb_x - ac4);
      end else if (bb_x == ac4) begin
         tag_in.kind = KIND_DOUBLE;
         mag_in      = '0;
      end else begin
         tag_in.kind = KIND_COMPLEX;
         mag_in      = MAG_W'(ac4 - bb_x);
      end
   end

   assign out_valid = v2_ff;
   assign out_mag   = mag_ff;
   assign out_tag   = tag_ff;
endmodule
`default_nettype wire

// ----- src/qrs_sqrt.sv -----
// Pipelined floor square root, one root bit per stage, tag carried along.
// Uses qrs_pkg.
`default_nettype none
module qrs_sqrt import qrs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [MAG_W-1:0] in_mag,
   input  sq_tag_type            in_tag,
   output logic                  out_valid,
   output logic [SQRT_W-1:0]     out_root,
   output sq_tag_type            out_tag
);
   logic              v_ff   [SQRT_W];
   logic [RAD_W-1:0]  rad_ff [SQRT_W];
   logic [REM_W-1:0]  rem_ff [SQRT_W];
   logic [SQRT_W-1:0] root_ff[SQRT_W];
   sq_tag_type        tag_ff [SQRT_W];

   logic [REM_W-1:0]  rem_in [SQRT_W];
   logic [SQRT_W-1:0] root_in[SQRT_W];

   always_comb begin
      logic [RAD_W-1:0]  pr;
      logic [REM_W-1:0]  prem, sh, trial;
      logic [SQRT_W-1:0] proot;
      for (int k = 0; k < SQRT_W; k++) begin
         if (k == 0) begin
            pr    = RAD_W'(in_mag);
            prem  = '0;
            proot = '0;
         end else begin
            pr    = rad_ff[k-1];
            prem  = rem_ff[k-1];
            proot = root_ff[k-1];
         end
         sh    = {prem[SQRT_W-1:0], pr[RAD_W-1-2*k -: 2]};
         trial = {proot, 2'b01};
         if (sh >= trial) begin
            rem_in[k]  = sh - trial;
            root_in[k] = {proot[SQRT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = sh;
            root_in[k] = {proot[SQRT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_W; k++) v_ff[k] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < SQRT_W; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      rad_ff[0] <= RAD_W'(in_mag);
      tag_ff[0] <= in_tag;
      for (int k = 1; k < SQRT_W; k++) begin
         rad_ff[k] <= rad_ff[k-1];
         tag_ff[k] <= tag_ff[k-1];
      end
      for (int k = 0; k < SQRT_W; k++) begin
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
      end
   end

   assign out_valid = v_ff[SQRT_W-1];
   assign out_root  = root_ff[SQRT_W-1];
   assign out_tag   = tag_ff[SQRT_W-1];
endmodule
`default_nettype wire

// ----- src/qrs_div.sv -----
// Pipelined restoring divider of magnitudes, one quotient bit per stage.
// Uses qrs_pkg; the sign bit rides along with the operands.
`default_nettype none
module qrs_div import qrs_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [NUM_MAG_W-1:0] in_num,
   input  wire logic [DEN_W-1:0]     in_den,
   input  wire logic                 in_neg,
   output logic                      out_valid,
   output logic [DVD_W-1:0]          out_quot,
   output logic                      out_neg
);
   logic             v_ff   [DVD_W];
   logic [DVD_W-1:0] dvd_ff [DVD_W];
   logic [DEN_W-1:0] den_ff [DVD_W];
   logic             neg_ff [DVD_W];
   logic [DEN_W-1:0] rem_ff [DVD_W];
   logic [DVD_W-1:0] q_ff   [DVD_W];

   logic [DVD_W-1:0] dvd0;
   logic [DEN_W-1:0] rem_in [DVD_W];
   logic [DVD_W-1:0] q_in   [DVD_W];

   assign dvd0 = {in_num, {FRAC_BITS{1'b0}}};

   always_comb begin
      logic [DVD_W-1:0] pd, pq;
      logic [DEN_W-1:0] pden, prem;
      logic [DEN_W:0]   sh;
      for (int k = 0; k < DVD_W; k++) begin
         if (k == 0) begin
            pd   = dvd0;
            pden = in_den;
            prem = '0;
            pq   = '0;
         end else begin
            pd   = dvd_ff[k-1];
            pden = den_ff[k-1];
            prem = rem_ff[k-1];
            pq   = q_ff[k-1];
         end
         sh      = {prem, pd[DVD_W-1-k]};
         q_in[k] = pq;
         if (sh >= {1'b0, pden}) begin
            rem_in[k]          = DEN_W'(sh - {1'b0, pden});
            q_in[k][DVD_W-1-k] = 1'b1;
         end else begin
            rem_in[k] = DEN_W'(sh);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DVD_W; k++) v_ff[k] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < DVD_W; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff[0] <= dvd0;
      den_ff[0] <= in_den;
      neg_ff[0] <= in_neg;
      for (int k = 1; k < DVD_W; k++) begin
         dvd_ff[k] <= dvd_ff[k-1];
         den_ff[k] <= den_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
      end
      for (int k = 0; k < DVD_W; k++) begin
         rem_ff[k] <= rem_in[k];
         q_ff[k]   <= q_in[k];
      end
   end

   assign out_valid = v_ff[DVD_W-1];
   assign out_quot  = q_ff[DVD_W-1];
   assign out_neg   = neg_ff[DVD_W-1];
endmodule
`default_nettype wire

// ----- src/quadratic_root_solver.sv -----
// Quadratic root solver: one coefficient set accepted per cycle, never busy
// outside reset. From the accepting edge to the strobe a set passes through
// 2 front stages, 17 square-root stages, 1 numerator stage, 34 divider stages
// (one quotient bit each) and 1 output register. The receiver cannot stall.
// Synchronous reset empties the pipeline; beats in flight are dropped.
`default_nettype none
`include "quadratic_root_solver_macros.svh"
module quadratic_root_solver import qrs_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [COEF_WIDTH-1:0] req_coef_a,
   input  wire logic signed [COEF_WIDTH-1:0] req_coef_b,
   input  wire logic signed [COEF_WIDTH-1:0] req_coef_c,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_root_kind,
   output logic signed [OUT_WIDTH-1:0]       rsp_root_first,
   output logic signed [OUT_WIDTH-1:0]       rsp_root_second,
   output logic signed [OUT_WIDTH-1:0]       rsp_imag_part
);
   logic             fr_valid;
   logic [MAG_W-1:0] fr_mag;
   sq_tag_type       fr_tag;

   logic              sq_valid;
   logic [SQRT_W-1:0] sq_root;
   sq_tag_type        sq_tag;

   logic signed [NUM_W-1:0] nb, sv, na, nbb;
   logic nv_ff;
   logic [NUM_MAG_W-1:0] na_mag_ff, nb_mag_ff;
   logic na_neg_ff, nb_neg_ff;
   logic [DEN_W-1:0] den_ff;
   kind_type kind_num_ff;
   kind_type kind_dly_ff[DVD_W];

   logic qa_valid, qb_valid, qa_neg, qb_neg;
   logic [DVD_W-1:0] qa, qb;
   logic signed [OUT_WIDTH-1:0] ra, rb;

   logic rv_ff;
   kind_type kind_ff, kind_out_in;
   logic signed [OUT_WIDTH-1:0] first_ff, second_ff, imag_ff;
   logic signed [OUT_WIDTH-1:0] first_in, second_in, imag_in;

   assign busy = reset;

   qrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .coef_a    (req_coef_a),
      .coef_b    (req_coef_b),
      .coef_c    (req_coef_c),
      .out_valid (fr_valid),
      .out_mag   (fr_mag),
      .out_tag   (fr_tag)
   );

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_mag    (fr_mag),
      .in_tag    (fr_tag),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   // numerators: A gives the first root, B the second root or the imaginary part
   always_comb begin
      nb = NUM_W'(sq_tag.neg_b);
      sv = signed'(NUM_W'(sq_root));
      case (sq_tag.kind)
         KIND_TWO_REAL: begin
            na  = nb + sv;
            nbb = nb - sv;
         end
         KIND_COMPLEX: begin
            na  = nb;
            nbb = sv;
         end
         default: begin
            na  = nb;
            nbb = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         nv_ff <= sq_valid;
         rv_ff <= qa_valid;
      end
   end

   always_ff @(posedge clock) begin
      na_mag_ff   <= na[NUM_W-1] ? NUM_MAG_W'(-na) : NUM_MAG_W'(na);
      nb_mag_ff   <= nbb[NUM_W-1] ? NUM_MAG_W'(-nbb) : NUM_MAG_W'(nbb);
      na_neg_ff   <= na[NUM_W-1] ^ sq_tag.den_neg;
      nb_neg_ff   <= nbb[NUM_W-1] ^ sq_tag.den_neg;
      den_ff      <= sq_tag.den_mag;
      kind_num_ff <= sq_tag.kind;
      kind_dly_ff[0] <= kind_num_ff;
      for (int k = 1; k < DVD_W; k++) kind_dly_ff[k] <= kind_dly_ff[k-1];
      kind_ff   <= kind_out_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      imag_ff   <= imag_in;
   end

   qrs_div u_div_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (nv_ff),
      .in_num    (na_mag_ff),
      .in_den    (den_ff),
      .in_neg    (na_neg_ff),
      .out_valid (qa_valid),
      .out_quot  (qa),
      .out_neg   (qa_neg)
   );

   qrs_div u_div_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (nv_ff),
      .in_num    (nb_mag_ff),
      .in_den    (den_ff),
      .in_neg    (nb_neg_ff),
      .out_valid (qb_valid),
      .out_quot  (qb),
      .out_neg   (qb_neg)
   );

   assign ra = qa_neg ? -signed'(OUT_WIDTH'(qa)) : signed'(OUT_WIDTH'(qa));
   assign rb = qb_neg ? -signed'(OUT_WIDTH'(qb)) : signed'(OUT_WIDTH'(qb));

   always_comb begin
      kind_out_in = kind_dly_ff[DVD_W-1];
      case (kind_out_in)
         KIND_TWO_REAL: begin
            first_in  = ra;
            second_in = rb;
            imag_in   = '0;
         end
         KIND_DOUBLE: begin
            first_in  = ra;
            second_in = ra;
            imag_in   = '0;
         end
         KIND_COMPLEX: begin
            first_in  = ra;
            second_in = ra;
            imag_in   = rb;
         end
         default: begin
            first_in  = '0;
            second_in = '0;
            imag_in   = '0;
         end
      endcase
   end

   assign rsp_valid       = rv_ff;
   assign rsp_root_kind   = kind_ff;
   assign rsp_root_first  = first_ff;
   assign rsp_root_second = second_ff;
   assign rsp_imag_part   = imag_ff;

   `QRS_ASSERT_LAT(a_latency, clock, reset, start && !busy, PIPE_LAT, rsp_valid, "result beat missing after fixed latency")
   `QRS_ASSERT_NOW(a_div_lockstep, clock, reset, qa_valid || qb_valid, qa_valid && qb_valid, "dividers out of step")
   `QRS_ASSERT_NOW(a_shared_root, clock, reset, rsp_valid && rsp_root_kind != KIND_TWO_REAL, rsp_root_first == rsp_root_second, "roots differ for shared case")
   `QRS_ASSERT_NOW(a_imag_zero, clock, reset, rsp_valid && rsp_root_kind != KIND_COMPLEX, rsp_imag_part == '0, "imaginary part set for real case")
endmodule
`default_nettype wire
